@@ hdl/sha256_stream_hasher_assert.svh @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA256_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA256_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Beat types, controller/datapath command and status, round constants and
// the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef logic [1:0] pad_sel_t;

  localparam pad_sel_t SEL_MSG   = 2'd0;
  localparam pad_sel_t SEL_PAD80 = 2'd1;
  localparam pad_sel_t SEL_ZERO  = 2'd2;
  localparam pad_sel_t SEL_LEN   = 2'd3;

  typedef struct packed {
    logic       push;
    pad_sel_t   sel;
    logic       round;
    logic       add;
    logic       init;
    logic [5:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_56;
    logic fill_ge56;
  } dp_stat_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

@@ hdl/sha256_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream channel
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface sha256_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/sha256_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte shift block, rolling schedule, working variables, hash state and
// message length counter, driven by the controller's commands.
// ----------------------------------------------------------------------------
module sha256_dp import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  msg_byte,
  output dp_stat_t    stat,
  output logic [31:0] digest_word
);

  logic [511:0] blk_r;
  logic [31:0]  h_r [8];
  logic [31:0]  wv_r [8];
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;

  logic [7:0]  push_byte;
  logic [31:0] w0, w1, w9, w14, new_w;
  logic [31:0] t1, t2, ch, maj;

  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];

  assign new_w = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
  assign ch    = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign maj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1    = wv_r[7] + big_sigma1(wv_r[4]) + ch + ROUND_K[cmd.cnt] + w0;
  assign t2    = big_sigma0(wv_r[0]) + maj;

  always_comb begin
    unique case (cmd.sel)
      SEL_MSG:   push_byte = msg_byte;
      SEL_PAD80: push_byte = 8'h80;
      SEL_ZERO:  push_byte = 8'h00;
      SEL_LEN:   push_byte = bits_r[{~cmd.cnt[2:0], 3'b000} +: 8];
      default:   push_byte = 8'h00;
    endcase
  end

  assign stat.fill_last = (fill_r == 6'd63);
  assign stat.fill_56   = (fill_r == 6'd56);
  assign stat.fill_ge56 = &fill_r[5:3];
  assign digest_word    = h_r[cmd.cnt[2:0]];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r <= {blk_r[503:0], push_byte};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], new_w};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= INIT_H;
      wv_r   <= INIT_H;
      fill_r <= '0;
      bits_r <= '0;
    end else begin
      if (cmd.push) begin
        fill_r <= fill_r + 6'd1;
        if (cmd.sel == SEL_MSG) begin
          bits_r <= bits_r + 64'd8;
        end
      end
      if (cmd.round) begin
        wv_r[0] <= t1 + t2;
        wv_r[1] <= wv_r[0];
        wv_r[2] <= wv_r[1];
        wv_r[3] <= wv_r[2];
        wv_r[4] <= wv_r[3] + t1;
        wv_r[5] <= wv_r[4];
        wv_r[6] <= wv_r[5];
        wv_r[7] <= wv_r[6];
      end
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i]  <= h_r[i] + wv_r[i];
          wv_r[i] <= h_r[i] + wv_r[i];
        end
      end
      if (cmd.init) begin
        h_r    <= INIT_H;
        wv_r   <= INIT_H;
        fill_r <= '0;
        bits_r <= '0;
      end
    end
  end

endmodule

@@ hdl/sha256_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorption, padding, the 64 rounds, the state update and
// the digest beats, and owns both channel handshakes.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_assert.svh"

module sha256_ctrl import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_has_byte,
  input  logic     in_is_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PAD80 = 3'd3;
  localparam logic [2:0] S_PADZ  = 3'd4;
  localparam logic [2:0] S_LEN   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [1:0] PH_DATA  = 2'd0;
  localparam logic [1:0] PH_PAD   = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       last_r, last_nxt;
  logic       wrap_r, wrap_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    wrap_nxt  = wrap_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = in_is_last;
          if (in_has_byte) begin
            cmd.push = 1'b1;
            cmd.sel  = SEL_MSG;
          end
          if (in_has_byte && stat.fill_last) begin
            state_nxt = S_ROUND;
            phase_nxt = PH_DATA;
            cnt_nxt   = '0;
          end else if (in_is_last) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        cnt_nxt = '0;
        unique case (phase_r)
          PH_DATA:  state_nxt = last_r ? S_PAD80 : S_IDLE;
          PH_PAD:   state_nxt = S_PADZ;
          PH_FINAL: state_nxt = S_EMIT;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_PAD80: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_PAD80;
        wrap_nxt = stat.fill_ge56;
        if (stat.fill_last) begin
          state_nxt = S_ROUND;
          phase_nxt = PH_PAD;
          cnt_nxt   = '0;
          wrap_nxt  = 1'b0;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (stat.fill_56 && !wrap_r) begin
          state_nxt = S_LEN;
          cnt_nxt   = '0;
        end else begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_ZERO;
          if (stat.fill_last) begin
            state_nxt = S_ROUND;
            phase_nxt = PH_PAD;
            cnt_nxt   = '0;
            wrap_nxt  = 1'b0;
          end
        end
      end
      S_LEN: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_LEN;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r[2:0] == 3'd7) begin
          state_nxt = S_ROUND;
          phase_nxt = PH_FINAL;
          cnt_nxt   = '0;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r[2:0] == 3'd7) begin
            cmd.init  = 1'b1;
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
            last_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DATA;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      wrap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

  `SHA256_ASSERT_SAME(a_no_in_during_emit, out_valid, !in_ready,
    "input taken while digest beats are pending")
  `SHA256_ASSERT_NEXT(a_rounds_end_in_add, (state_r == S_ROUND) && (cnt_r == 6'd63),
    (state_r == S_ADD) && (cnt_r == 6'd0), "round count did not end in the state update")
  `SHA256_ASSERT_NEXT(a_full_block_compresses,
    in_valid && in_ready && in_has_byte && stat.fill_last,
    (state_r == S_ROUND) && (cnt_r == 6'd0), "full block did not start compression")
  `SHA256_ASSERT_NEXT(a_digest_done_idle, out_valid && out_ready && (cnt_r[2:0] == 3'd7),
    (state_r == S_IDLE) && !out_valid, "final digest beat did not return to idle")

endmodule

@@ hdl/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Streaming SHA-256 over a byte channel, emitting an eight-word digest.
// ----------------------------------------------------------------------------
// The input channel takes one beat per message byte (msg_byte with has_byte)
// and is_last closes the message; a beat with neither flag changes nothing.
// The output channel returns the digest as eight beats, word_index 0 first,
// with last_word set on the eighth.
// The beat that fills a 64-byte block starts the compression: the rounds of
// the single round unit and a state update, while the input is held off.
// After a last beat the controller pushes the 0x80 byte, zero bytes until 56
// bytes of the block are filled, and the eight length bytes, compressing
// whenever a block fills; a last byte that fills a block first compresses that
// block. While the receiver is ready the digest goes at one beat per cycle.
// While the receiver stalls the current digest beat holds and no input is
// taken; after the eighth beat the state returns to the initial hash values.
// Reset loads the initial hash values and clears the fill count and the length counter.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha256_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  sha256_stream_if.sink   in_s,
  sha256_stream_if.source out_s
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] digest_word;

  sha256_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_s.valid),
    .in_has_byte (in_s.payload.has_byte),
    .in_is_last  (in_s.payload.is_last),
    .in_ready    (in_s.ready),
    .out_valid   (out_s.valid),
    .out_ready   (out_s.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .msg_byte    (in_s.payload.msg_byte),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign out_s.payload.digest_word = digest_word;
  assign out_s.payload.word_index  = cmd.cnt[2:0];
  assign out_s.payload.last_word   = (cmd.cnt[2:0] == 3'd7);

endmodule

@@ bench/sha256_digest_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels of the stream hasher, hashes every accepted byte
// beat in its own SHA-256 model, and compares each digest beat with the
// oldest expected word. It reports the mismatch count and the number of
// digest words still expected to the bench top.
// ----------------------------------------------------------------------------
module sha256_digest_checker import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sha256_stream_if in_ch,
  sha256_stream_if out_ch,
  output int       mismatch_cnt,
  output int       words_pending
);

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0] chain_h [8];
  logic [7:0]  blk [64];
  int          blk_len;
  logic [63:0] msg_len_bits;
  out_item_t   digest_q [$];
  int          err_total;
  int          beat_cnt;

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void restart_msg();
    for (int i = 0; i < 8; i++) begin
      chain_h[i] = H_START[i];
    end
    blk_len = 0;
    msg_len_bits = '0;
  endfunction

  function void sha_compress();
    logic [31:0] w [16];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
    logic [31:0] x, y, s0, s1, t1, t2;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
    end
    va = chain_h[0]; vb = chain_h[1]; vc = chain_h[2]; vd = chain_h[3];
    ve = chain_h[4]; vf = chain_h[5]; vg = chain_h[6]; vh = chain_h[7];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        x = w[(r - 15) & 15];
        y = w[(r - 2) & 15];
        s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
        s1 = ror(y, 17) ^ ror(y, 19) ^ (y >> 10);
        w[r & 15] = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
      end
      t1 = vh + (ror(ve, 6) ^ ror(ve, 11) ^ ror(ve, 25)) + ((ve & vf) ^ (~ve & vg))
           + K_ROUND[r] + w[r & 15];
      t2 = (ror(va, 2) ^ ror(va, 13) ^ ror(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    chain_h[0] += va; chain_h[1] += vb; chain_h[2] += vc; chain_h[3] += vd;
    chain_h[4] += ve; chain_h[5] += vf; chain_h[6] += vg; chain_h[7] += vh;
  endfunction

  function void finish_digest();
    int fill;
    out_item_t word;
    fill = blk_len;
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      for (int i = fill; i < 64; i++) begin
        blk[i] = 8'h00;
      end
      sha_compress();
      fill = 0;
    end
    for (int i = fill; i < 56; i++) begin
      blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      blk[63 - i] = msg_len_bits[8 * i +: 8];
    end
    sha_compress();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = chain_h[i];
      word.word_index = 3'(i);
      word.last_word = (i == 7);
      digest_q.push_back(word);
    end
    restart_msg();
  endfunction

  function void absorb_beat(input in_item_t beat);
    if (beat.has_byte) begin
      blk[blk_len] = beat.msg_byte;
      blk_len++;
      msg_len_bits += 64'd8;
      if (blk_len == 64) begin
        sha_compress();
        blk_len = 0;
      end
    end
    if (beat.is_last) begin
      finish_digest();
    end
  endfunction

  initial begin
    restart_msg();
    err_total = 0;
    beat_cnt = 0;
  end

  always @(posedge clk) begin
    in_item_t  beat_in;
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      restart_msg();
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        beat_in = in_ch.payload;
        absorb_beat(beat_in);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = out_ch.payload;
        if (digest_q.size() == 0) begin
          err_total++;
          if (err_total <= 10) begin
            $display("digest beat %0d unexpected: word %h index %0d last %b",
                     beat_cnt, got.digest_word, got.word_index, got.last_word);
          end
        end else begin
          want = digest_q.pop_front();
          if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
              got.last_word !== want.last_word) begin
            err_total++;
            if (err_total <= 10) begin
              $display("digest beat %0d: expected word %h index %0d last %b, got word %h index %0d last %b",
                       beat_cnt, want.digest_word, want.word_index, want.last_word,
                       got.digest_word, got.word_index, got.last_word);
            end
          end
        end
        beat_cnt++;
      end
    end
    mismatch_cnt <= err_total;
    words_pending <= digest_q.size();
  end

endmodule

@@ bench/tb_sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds directed messages (empty, single byte, short text, idle and ignored
// bytes) and then random messages around the padding and block boundaries,
// under phases of sender idling and receiver stalls. The digest checker
// predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
  import sha256_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int BOUNDARY_LEN [13] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   item_cnt = 0;
  int   mismatch_cnt;
  int   words_pending;

  sha256_stream_if #(.payload_t(in_item_t))  in_if();
  sha256_stream_if #(.payload_t(out_item_t)) out_if();

  sha256_stream_hasher i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if.sink),
    .out_s (out_if.source)
  );

  sha256_digest_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .mismatch_cnt  (mismatch_cnt),
    .words_pending (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
    in_item_t beat;
    beat.msg_byte = b;
    beat.has_byte = has;
    beat.is_last = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.payload <= beat;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (has || last) begin
      item_cnt++;
    end
  endtask

  task automatic send_message(input int len, input bit last_on_byte, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_beat(8'($urandom_range(255)), 1'b1, last_on_byte && (i == len - 1));
    end
    if (!last_on_byte || len == 0) begin
      send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    int rand_start;
    int phase;
    int len;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message with an ignored byte, then a zero byte after an idle beat.
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b0, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);

    rand_start = item_cnt;
    while (item_cnt - rand_start < RANDOM_ITEMS) begin
      phase = (item_cnt - rand_start) * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 72;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct = 9;
          recv_stall_pct = 9;
        end
      endcase
      if ($urandom_range(99) < 30) begin
        len = BOUNDARY_LEN[$urandom_range(12)];
      end else begin
        len = $urandom_range(40);
      end
      send_message(len, 1'($urandom_range(1)), 8);
    end
    in_if.valid <= 1'b0;

    do @(posedge clk); while (words_pending != 0);
    repeat (300) @(posedge clk);
    if (mismatch_cnt != 0) begin
      $display("[sha256_stream_hasher] ERROR");
    end else begin
      $display("[sha256_stream_hasher] OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[sha256_stream_hasher] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sha256_pkg.sv
hdl/sha256_stream_if.sv
hdl/sha256_dp.sv
hdl/sha256_ctrl.sv
hdl/sha256_stream_hasher.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_stream_hasher.sv
